[hdl/imucal_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package imucal_pkg;
    localparam int SW = 32;
    localparam int IW = 48;
    localparam int FB = 16;
    localparam logic [31:0] K_DEG2RAD  = 32'd1144;
    localparam logic [31:0] K_GRAV     = 32'd642689;
    localparam logic [31:0] K_INV_GRAV = 32'd6683;

    typedef logic signed [SW-1:0] t_smp;
    typedef struct packed {
        t_smp gx, gy, gz, ax, ay, az, mx, my, mz;
    } t_in;
    typedef struct packed {
        t_smp gx, gy, gz, ax, ay, az, cx, cy, cz, sx, sy, sz;
    } t_out;

    typedef enum logic [2:0] {
        R_GBIAS = 3'd0, R_ABIAS = 3'd1, R_ASCALE = 3'd2, R_AMIS = 3'd3,
        R_MBIAS = 3'd4, R_MSCALE = 3'd5, R_ALPHA = 3'd6, R_NONE = 3'd7
    } t_reg;

    // Saturate a 50-bit signed value to a narrower signed width.
    function automatic logic signed [IW-1:0] sat_in(input logic signed [IW+1:0] v);
        logic signed [IW+1:0] hi;
        logic signed [IW+1:0] lo;
        hi = (IW+2)'((64'sd1 <<< (IW-1)) - 1);
        lo = -hi - 1;
        if (v > hi) return hi[IW-1:0];
        if (v < lo) return lo[IW-1:0];
        return v[IW-1:0];
    endfunction

    function automatic t_smp sat_out(input logic signed [IW+1:0] v);
        logic signed [IW+1:0] hi;
        logic signed [IW+1:0] lo;
        hi = (IW+2)'((64'sd1 <<< (SW-1)) - 1);
        lo = -hi - 1;
        if (v > hi) return hi[SW-1:0];
        if (v < lo) return lo[SW-1:0];
        return v[SW-1:0];
    endfunction
endpackage
`default_nettype wire

[hdl/imucal_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface imucal_in_if import imucal_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface imucal_out_if import imucal_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/imu_three_axis_calibrator.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Protocol       Payload
// s_in      in   valid/ready    nine Q16.16 samples, one request
// m_out     out  valid/ready    twelve Q16.16 results
// apb       in   APB write/read seven calibration registers, 8-byte stride
//
// Each request passes through the back end in order: it is taken, 15 steps for
// gyro, accel, mag and filter, 6 misalignment products, a load of the mixed
// values, 1/g on 3 axes, then the hand-off of the result. The back end takes no
// new request until the result of the last one has been handed off.
// A two-entry queue keeps accepting while the back end works or stalls, until full.
// Reset (synchronous, active low) loads register defaults and clears the filter.
module imu_three_axis_calibrator
    import imucal_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    imucal_in_if.sink   s_in,
    imucal_out_if.source m_out,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [5:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    logic [62:0] r_gb, r_ab, r_as, r_mb, r_ms;
    logic [59:0] r_am;
    logic [15:0] r_al;
    t_reg        w_idx;
    logic        w_qv, w_take, w_busy;
    t_in         w_qd;

    assign pready = 1'b1;
    assign w_idx  = t_reg'(paddr[5:3]);

    always_comb begin
        case (w_idx)
            R_GBIAS:  prdata = {1'b0, r_gb};
            R_ABIAS:  prdata = {1'b0, r_ab};
            R_ASCALE: prdata = {1'b0, r_as};
            R_AMIS:   prdata = {4'b0, r_am};
            R_MBIAS:  prdata = {1'b0, r_mb};
            R_MSCALE: prdata = {1'b0, r_ms};
            R_ALPHA:  prdata = {48'b0, r_al};
            default:  prdata = '0;
        endcase
    end

    // write registers on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gb <= '0; r_ab <= '0; r_am <= '0; r_mb <= '0;
            r_as <= 63'd288230513590730752;
            r_ms <= 63'd288230513590730752;
            r_al <= 16'd3277;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                R_GBIAS:  r_gb <= pwdata[62:0];
                R_ABIAS:  r_ab <= pwdata[62:0];
                R_ASCALE: r_as <= pwdata[62:0];
                R_AMIS:   r_am <= pwdata[59:0];
                R_MBIAS:  r_mb <= pwdata[62:0];
                R_MSCALE: r_ms <= pwdata[62:0];
                R_ALPHA:  r_al <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    imucal_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_in.valid), .o_ready(s_in.ready), .i_data(s_in.data),
        .o_valid(w_qv), .i_take(w_take), .o_data(w_qd)
    );

    imucal_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_take(w_take), .i_data(w_qd),
        .i_gbias(r_gb), .i_abias(r_ab), .i_ascale(r_as), .i_amis(r_am),
        .i_mbias(r_mb), .i_mscale(r_ms), .i_alpha(r_al),
        .o_valid(m_out.valid), .i_ready(m_out.ready), .o_data(m_out.data),
        .o_busy(w_busy)
    );

    // hold the result while the sink stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && !m_out.ready |=> m_out.valid && $stable(m_out.data))
        else $error("result changed under stall");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> !w_busy)
        else $error("request taken while busy");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> w_busy)
        else $error("result without busy");
endmodule
`default_nettype wire

[hdl/imucal_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// Two-entry queue that decouples intake from the compute sequencer.
module imucal_front
    import imucal_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  wire  i_take,
    output t_in  o_data
);
    t_in        r_q [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_take && o_valid;

    always_comb begin
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ w_pop;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) r_q[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

[hdl/imucal_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequencer over a shared 48x21 multiplier, plus a 48x10 one for the
// misalignment terms; one product per step.
module imucal_back
    import imucal_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_take,
    input  t_in         i_data,
    input  wire  [62:0] i_gbias,
    input  wire  [62:0] i_abias,
    input  wire  [62:0] i_ascale,
    input  wire  [59:0] i_amis,
    input  wire  [62:0] i_mbias,
    input  wire  [62:0] i_mscale,
    input  wire  [15:0] i_alpha,
    output logic        o_valid,
    input  wire         i_ready,
    output t_out        o_data,
    output logic        o_busy
);
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} t_st;
    t_st r_st;
    logic [4:0] r_stp;
    t_in  r_in;
    t_out r_res;
    logic signed [IW-1:0] r_t [3];
    logic signed [IW+1:0] r_acc;
    logic signed [SW-1:0] r_f [3];

    // operand select
    logic signed [IW-1:0] w_a;
    logic signed [20:0]   w_b;
    logic signed [81:0]   w_p;
    logic signed [IW+1:0] w_fl;
    logic [1:0]           w_ax;
    logic signed [20:0]   w_gb, w_ab, w_as, w_mb, w_ms;
    logic signed [IW-1:0] w_mc_in;
    logic signed [SW:0]   w_diff;

    function automatic logic signed [IW+1:0] mulf(input logic signed [81:0] p);
        logic signed [81:0] s;
        s = p >>> FB;
        if (s > 82'sd140737488355327) return 50'sd140737488355327;
        if (s < -82'sd140737488355328) return -50'sd140737488355328;
        return s[IW+1:0];
    endfunction

    always_comb begin
        w_ax = (r_stp < 5'd3) ? r_stp[1:0] : (r_stp < 5'd6) ? 2'(r_stp - 5'd3)
             : (r_stp < 5'd9) ? 2'(r_stp - 5'd6) : (r_stp < 5'd12) ? 2'(r_stp - 5'd9)
             : (r_stp < 5'd15) ? 2'(r_stp - 5'd12) : 2'(r_stp - 5'd15);
        w_gb = i_gbias[21*w_ax +: 21];
        w_ab = i_abias[21*w_ax +: 21];
        w_as = i_ascale[21*w_ax +: 21];
        w_mb = i_mbias[21*w_ax +: 21];
        w_ms = i_mscale[21*w_ax +: 21];
        w_mc_in = (w_ax == 2'd0) ? IW'(r_in.mx) : (w_ax == 2'd1) ? IW'(r_in.my)
                : IW'(r_in.mz);
        w_diff = (w_ax == 2'd0) ? (SW+1)'(r_res.cx) - (SW+1)'(r_f[0])
               : (w_ax == 2'd1) ? (SW+1)'(r_res.cy) - (SW+1)'(r_f[1])
               : (SW+1)'(r_res.cz) - (SW+1)'(r_f[2]);
        w_a = '0;
        w_b = '0;
        if (r_stp < 5'd3) begin
            w_a = (w_ax == 2'd0) ? IW'(r_in.gx) : (w_ax == 2'd1) ? IW'(r_in.gy) : IW'(r_in.gz);
            w_b = 21'(K_DEG2RAD);
        end else if (r_stp < 5'd6) begin
            w_a = (w_ax == 2'd0) ? IW'(r_in.ax) : (w_ax == 2'd1) ? IW'(r_in.ay) : IW'(r_in.az);
            w_b = 21'(K_GRAV);
        end else if (r_stp < 5'd9) begin
            w_a = r_t[w_ax];
            w_b = w_as;
        end else if (r_stp < 5'd12) begin
            w_a = w_mc_in + (IW'(w_mb) <<< 8);
            w_b = w_ms;
        end else if (r_stp < 5'd15) begin
            w_a = IW'(w_diff);
            w_b = 21'(i_alpha);
        end else begin
            // 1/g scaling of the mixed values; the mixing (two products per axis) runs in the misalignment steps below
            w_a = r_t[w_ax];
            w_b = 21'(K_INV_GRAV);
        end
        w_p  = w_a * w_b;
        w_fl = mulf(w_p);
    end

    // misalignment runs in its own small step counter
    logic [2:0] r_mi;
    logic signed [IW-1:0] w_ma, w_na;
    logic signed [9:0]    w_mm;
    logic signed [81:0]   w_mp;
    always_comb begin
        // r_mi: axis*2 + term; accumulator built in r_acc
        case (r_mi)
            3'd0: begin w_ma = r_t[1]; w_mm = i_amis[9:0];   end
            3'd1: begin w_ma = r_t[2]; w_mm = i_amis[19:10]; end
            3'd2: begin w_ma = r_t[0]; w_mm = i_amis[29:20]; end
            3'd3: begin w_ma = r_t[2]; w_mm = i_amis[39:30]; end
            3'd4: begin w_ma = r_t[0]; w_mm = i_amis[49:40]; end
            default: begin w_ma = r_t[1]; w_mm = i_amis[59:50]; end
        endcase
        w_mp = w_ma * w_mm;
        w_na = (r_mi[2:1] == 2'd0) ? r_t[0] : (r_mi[2:1] == 2'd1) ? r_t[1] : r_t[2];
    end

    logic signed [IW-1:0] r_a [3];
    logic [1:0] r_ph;

    assign o_take  = (r_st == S_IDLE) && i_valid;
    assign o_valid = (r_st == S_OUT);
    assign o_data  = r_res;
    assign o_busy  = (r_st != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_stp <= '0;
            r_mi  <= '0;
            r_ph  <= '0;
            r_f[0] <= '0; r_f[1] <= '0; r_f[2] <= '0;
        end else begin
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_in <= i_data;
                    r_st <= S_RUN;
                    r_stp <= '0;
                    r_ph  <= '0;
                    r_mi  <= '0;
                end
                S_RUN: begin
                    if (r_stp < 5'd15) begin
                        r_stp <= r_stp + 5'd1;
                        case (r_stp)
                            5'd0: r_res.gx <= sat_out(w_fl + ((IW+2)'(w_gb)));
                            5'd1: r_res.gy <= sat_out(w_fl + ((IW+2)'(w_gb)));
                            5'd2: r_res.gz <= sat_out(w_fl + ((IW+2)'(w_gb)));
                            5'd3, 5'd4, 5'd5:
                                r_t[w_ax] <= sat_in(w_fl + ((IW+2)'(w_ab)));
                            5'd6, 5'd7, 5'd8: r_t[w_ax] <= w_fl[IW-1:0];
                            5'd9:  r_res.cx <= sat_out(w_fl);
                            5'd10: r_res.cy <= sat_out(w_fl);
                            5'd11: r_res.cz <= sat_out(w_fl);
                            default: begin
                                r_f[w_ax] <= sat_out((IW+2)'(r_f[w_ax]) + w_fl);
                                case (w_ax)
                                    2'd0: r_res.sx <= sat_out((IW+2)'(r_f[0]) + w_fl);
                                    2'd1: r_res.sy <= sat_out((IW+2)'(r_f[1]) + w_fl);
                                    default: r_res.sz <= sat_out((IW+2)'(r_f[2]) + w_fl);
                                endcase
                            end
                        endcase
                    end else if (r_ph == 2'd0) begin
                        // accumulate misalignment terms, two per axis
                        if (!r_mi[0]) r_acc <= (IW+2)'(w_na) + mulf(82'(w_mp));
                        else r_a[r_mi[2:1]] <= sat_in(r_acc + mulf(82'(w_mp)));
                        if (r_mi == 3'd5) begin
                            r_ph <= 2'd1;
                        end
                        r_mi <= r_mi + 3'd1;
                    end else if (r_ph == 2'd1) begin
                        // load the mixed values for the 1/g pass
                        r_t[0] <= r_a[0]; r_t[1] <= r_a[1]; r_t[2] <= r_a[2];
                        r_mi <= '0;
                        r_ph <= 2'd2;
                    end else begin
                        // final 1/g scaling, one axis per cycle
                        case (r_mi)
                            3'd0: r_res.ax <= sat_out(w_fl);
                            3'd1: r_res.ay <= sat_out(w_fl);
                            default: r_res.az <= sat_out(w_fl);
                        endcase
                        r_stp <= r_stp + 5'd1;
                        r_mi  <= r_mi + 3'd1;
                        if (r_mi == 3'd2) r_st <= S_OUT;
                    end
                end
                S_OUT: if (i_ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[tb/imucal_checker.sv]
`timescale 1ns / 1ps
module imucal_checker
    import imucal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    imucal_in_if        in_ch,
    imucal_out_if       out_ch,
    output int          o_fails,
    output int          o_pending
);
    typedef logic signed [127:0] wide_t;

    logic [63:0] cal_reg [7];
    wide_t       mag_lpf [3];
    t_out        cal_expected_q [$];

    // values sampled mid-cycle, applied at the next rising edge
    logic        s_rst = 1'b0;
    logic        s_wr = 1'b0;
    logic [5:0]  s_addr = '0;
    logic [63:0] s_wdata = '0;
    logic        s_in_fire = 1'b0;
    logic        s_out_fire = 1'b0;
    t_in         s_in_data;
    t_out        s_out_data;

    initial begin
        o_fails   = 0;
        o_pending = 0;
    end

    function automatic int reg_bits(t_reg r);
        case (r)
            R_AMIS:  return 60;
            R_ALPHA: return 16;
            default: return 63;
        endcase
    endfunction

    function automatic wide_t sat_to(wide_t v, int w);
        wide_t hi;
        hi = (wide_t'(1) <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // floored product scaled by 2^-s, clamped to the inner width
    function automatic wide_t mul_floor(wide_t a, wide_t b, int s);
        wide_t p;
        p = a * b;
        return sat_to(p >>> s, IW);
    endfunction

    function automatic wide_t reg_field(t_reg r, int k, int w);
        wide_t x;
        wide_t m;
        m = (wide_t'(1) <<< w) - 1;
        x = wide_t'(cal_reg[r] >> (k * w)) & m;
        if (x[w-1]) x = x - (wide_t'(1) <<< w);
        return x;
    endfunction

    function automatic t_out calibrate(t_in d);
        wide_t gin [3];
        wide_t ain [3];
        wide_t min_ [3];
        wide_t tacc [3];
        wide_t gv, mc, f, acc;
        int    k;
        t_out  r;
        gin  = '{d.gx, d.gy, d.gz};
        ain  = '{d.ax, d.ay, d.az};
        min_ = '{d.mx, d.my, d.mz};
        for (int i = 0; i < 3; i++) begin
            gv = sat_to(mul_floor(gin[i], K_DEG2RAD, FB) + reg_field(R_GBIAS, i, 21), SW);
            tacc[i] = sat_to(mul_floor(ain[i], K_GRAV, FB) + reg_field(R_ABIAS, i, 21), IW);
            tacc[i] = mul_floor(tacc[i], reg_field(R_ASCALE, i, 21), 16);
            mc = sat_to(mul_floor(min_[i] + (reg_field(R_MBIAS, i, 21) <<< 8),
                                  reg_field(R_MSCALE, i, 21), 16), SW);
            f = sat_to(mag_lpf[i] + mul_floor(mc - mag_lpf[i],
                                              wide_t'(cal_reg[R_ALPHA][15:0]), 16), SW);
            mag_lpf[i] = f;
            r[(11 - i) * 32 +: 32] = gv[31:0];
            r[(5 - i) * 32 +: 32]  = mc[31:0];
            r[(2 - i) * 32 +: 32]  = f[31:0];
        end
        for (int i = 0; i < 3; i++) begin
            acc = tacc[i];
            for (int j = 0; j < 3; j++) begin
                if (j != i) begin
                    k = i * 2 + (j > i ? j - 1 : j);
                    acc = acc + mul_floor(tacc[j], reg_field(R_AMIS, k, 10), 16);
                end
            end
            acc = sat_to(acc, IW);
            acc = sat_to(mul_floor(acc, K_INV_GRAV, FB), SW);
            r[(8 - i) * 32 +: 32] = acc[31:0];
        end
        return r;
    endfunction

    always @(negedge i_clk) begin
        s_rst      = !i_rst_n;
        s_wr       = psel && penable && pwrite && pready;
        s_addr     = paddr;
        s_wdata    = pwdata;
        s_in_fire  = in_ch.valid && in_ch.ready;
        s_in_data  = in_ch.data;
        s_out_fire = out_ch.valid && out_ch.ready;
        s_out_data = out_ch.data;
    end

    always @(posedge i_clk) begin
        string fname [12];
        t_out  want;
        fname = '{"gyro_out_x", "gyro_out_y", "gyro_out_z", "acc_out_x", "acc_out_y",
                  "acc_out_z", "mag_cal_x", "mag_cal_y", "mag_cal_z", "mag_smooth_x",
                  "mag_smooth_y", "mag_smooth_z"};
        if (s_rst) begin
            cal_reg[R_GBIAS]  = '0;
            cal_reg[R_ABIAS]  = '0;
            cal_reg[R_ASCALE] = 64'd288230513590730752;
            cal_reg[R_AMIS]   = '0;
            cal_reg[R_MBIAS]  = '0;
            cal_reg[R_MSCALE] = 64'd288230513590730752;
            cal_reg[R_ALPHA]  = 64'd3277;
            for (int i = 0; i < 3; i++) mag_lpf[i] = 0;
            cal_expected_q.delete();
        end else begin
            // ignore writes past the last register
            if (s_wr && t_reg'(s_addr[5:3]) != R_NONE)
                cal_reg[s_addr[5:3]] = s_wdata &
                    ((64'd1 << reg_bits(t_reg'(s_addr[5:3]))) - 64'd1);
            if (s_in_fire) cal_expected_q.push_back(calibrate(s_in_data));
            if (s_out_fire) begin
                if (cal_expected_q.size() == 0) begin
                    $error("result with no request outstanding");
                    o_fails = o_fails + 1;
                end else begin
                    want = cal_expected_q.pop_front();
                    for (int f = 0; f < 12; f++) begin
                        if (want[(11 - f) * 32 +: 32] !== s_out_data[(11 - f) * 32 +: 32]) begin
                            $error("%s: expected %0d, got %0d", fname[f],
                                   $signed(want[(11 - f) * 32 +: 32]),
                                   $signed(s_out_data[(11 - f) * 32 +: 32]));
                            o_fails = o_fails + 1;
                        end
                    end
                end
            end
        end
        o_pending = cal_expected_q.size();
    end
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import imucal_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    int  fails;
    int  pending;
    int  phase = 0;
    bit  idle_off = 1'b0;  // long stretch with no idling on either side
    bit  held = 1'b0;
    int  hold_cnt = 0;
    longint cycles = 0;

    imucal_in_if  in_ch ();
    imucal_out_if out_ch ();

    imu_three_axis_calibrator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_ch),
        .m_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    imucal_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .o_fails   (fails),
        .o_pending (pending)
    );

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    // Hard stop well beyond the slowest legal run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off during phase 2 so the
    // input queue fills and back-pressures the sender.
    always @(posedge i_clk) begin
        if (phase == 2 && !held) begin
            held = 1'b1;
            hold_cnt = 400;
        end
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= idle_off || ($urandom_range(0, 99) >= 25);
        end
    end

    // Register write: setup phase, then access phase.
    task automatic reg_write(t_reg r, logic [63:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one request and hold it until the handshake completes.
    task automatic send_sample(t_in d);
        bit fire;
        in_ch.valid <= 1'b1;
        in_ch.data  <= d;
        do begin
            @(negedge i_clk);
            fire = in_ch.valid && in_ch.ready;
            @(posedge i_clk);
        end while (!fire);
        if (!idle_off && $urandom_range(0, 99) < 25) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Drain: let the last request be counted, wait for every result, then
    // let the back end settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            3: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in rand_item();
        t_in d;
        d.gx = rand_sample(); d.gy = rand_sample(); d.gz = rand_sample();
        d.ax = rand_sample(); d.ay = rand_sample(); d.az = rand_sample();
        d.mx = rand_sample(); d.my = rand_sample(); d.mz = rand_sample();
        return d;
    endfunction

    function automatic t_in same_item(logic [31:0] v);
        t_in d;
        d.gx = v; d.gy = v; d.gz = v; d.ax = v; d.ay = v; d.az = v;
        d.mx = v; d.my = v; d.mz = v;
        return d;
    endfunction

    function automatic logic [63:0] pack3(logic [20:0] v);
        return {1'b0, v, v, v};
    endfunction

    function automatic logic [63:0] pack6(logic [9:0] v);
        return {4'b0, v, v, v, v, v, v};
    endfunction

    // mode: 0 random, 1 all ones, 2 largest positive, 3 most negative, 4 zero
    task automatic load_regs(int mode);
        logic [63:0] v [7];
        case (mode)
            1: begin
                foreach (v[i]) v[i] = '1;
            end
            2: begin
                for (int i = 0; i < 6; i++) v[i] = pack3(21'h0F_FFFF);
                v[R_AMIS] = pack6(10'h1FF);
                v[R_ALPHA] = 64'hFFFF;
            end
            3: begin
                for (int i = 0; i < 6; i++) v[i] = pack3(21'h10_0000);
                v[R_AMIS] = pack6(10'h200);
                v[R_ALPHA] = 64'h8000;
            end
            4: begin
                foreach (v[i]) v[i] = '0;
            end
            default: begin
                foreach (v[i]) v[i] = {$urandom, $urandom};
            end
        endcase
        reg_write(R_GBIAS, v[R_GBIAS]);
        reg_write(R_ABIAS, v[R_ABIAS]);
        reg_write(R_ASCALE, v[R_ASCALE]);
        reg_write(R_AMIS, v[R_AMIS]);
        reg_write(R_MBIAS, v[R_MBIAS]);
        reg_write(R_MSCALE, v[R_MSCALE]);
        reg_write(R_ALPHA, v[R_ALPHA]);
        // past the last register: must change nothing
        reg_write(R_NONE, {$urandom, $urandom});
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (40) @(posedge i_clk);

        // Directed: extreme samples at reset settings, then at extreme settings.
        send_sample(same_item('0));
        send_sample(same_item(32'h7FFF_FFFF));
        send_sample(same_item(32'h8000_0000));
        send_sample(same_item(32'hFFFF_FFFF));
        send_sample(same_item(32'h0001_0000));
        send_sample(same_item(32'hAAAA_AAAA));
        send_sample(same_item(32'h5555_5555));
        drain();
        for (int m = 1; m <= 4; m++) begin
            load_regs(m);
            send_sample(same_item(32'h7FFF_FFFF));
            send_sample(same_item(32'h8000_0000));
            send_sample(same_item(32'h0001_0000));
            drain();
        end

        // Random phases, each with fresh settings; phase 1 runs without idling,
        // phase 2 sees the long result hold-off.
        for (int p = 0; p < 6; p++) begin
            phase    = p;
            idle_off = (p == 1);
            load_regs(p == 5 ? 2 : 0);
            for (int n = 0; n < 180; n++) send_sample(rand_item());
            drain();
        end
        idle_off = 1'b0;

        if (fails == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule

[filelist.f]
hdl/imucal_pkg.sv
hdl/imucal_if.sv
hdl/imucal_front.sv
hdl/imucal_back.sv
hdl/imu_three_axis_calibrator.sv
tb/imucal_checker.sv
tb/tb_top.sv
